/* rtl/core/assert_macros.svh */
// assertion helpers included by image_2d_convolution
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ICV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icv assertion failed");

// next-cycle implication, checked outside reset
`define ICV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icv assertion failed");

`endif

/* rtl/core/icv_pkg.sv */
// shared widths, register codes and constants of the image convolution block
// no dependencies
`default_nettype none

package icv_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 12;
    localparam int PROD_W     = 21;
    localparam int SUM_W      = 25;
    localparam int DIM_CFG_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    // register codes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW0    = 3'd2;

    localparam int IMAGE_WIDTH_RST  = 640;
    localparam int IMAGE_HEIGHT_RST = 480;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

endpackage

`default_nettype wire

/* rtl/core/icv_pix_if.sv */
// pixel input channel: valid, ready and the pixel payload
// depends on icv_pkg
`default_nettype none

interface icv_pix_if;
    import icv_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             drain;

    modport source (output valid, output pixel, output drain, input ready);
    modport sink   (input valid, input pixel, input drain, output ready);
endinterface

`default_nettype wire

/* rtl/core/icv_res_if.sv */
// result output channel: valid, ready and the filtered payload
// depends on icv_pkg
`default_nettype none

interface icv_res_if;
    import icv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] filtered;
    logic                    last;

    modport source (output valid, output filtered, output last, input ready);
    modport sink   (input valid, input filtered, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/image_2d_convolution.sv */
// top level of the zero-padded 2d convolution over a raster pixel stream
// depends on icv_pkg, icv_pix_if, icv_res_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Takes one pixel transaction per clock, every clock, as long as the output side keeps up.
// Result k of a frame appears after the transaction at stream position
// k + HALF * width + HALF has been taken, so the host appends that many drain transactions
// after the frame. The rate is set by the line memory: one read and one write of a
// (MASK_SIZE-1)-sample column word per cycle, read at acceptance and written back in the
// following cycle, with the written word forwarded when the next transaction hits the same
// column (width one, or a frame restart). An eight-entry output queue sits between the
// pipeline and the result channel; ready falls only when the queue plus the work in flight
// would fill it. Taps outside the frame are forced to zero from the output coordinates, so
// the line memory needs no clearing pass after reset.
// Configuration is taken at any write enable; geometry writes restart the frame.
module image_2d_convolution #(
    parameter int MASK_SIZE  = 3,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [icv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [icv_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    icv_pix_if.sink                               i_pix,
    icv_res_if.source                             o_res
);
    import icv_pkg::*;

    localparam int HALF    = (MASK_SIZE - 1) / 2;
    localparam int LINE_W  = (MASK_SIZE - 1) * PIX_W;
    localparam int ROWC_W  = MASK_SIZE * COEF_W;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int XW      = $clog2(MAX_HEIGHT);
    localparam int WDIM_W  = $clog2(MAX_WIDTH + MASK_SIZE);
    localparam int HDIM_W  = $clog2(MAX_HEIGHT + 2 * MASK_SIZE);
    localparam int LAG_W   = $clog2(2 * MAX_WIDTH + MASK_SIZE);
    localparam int W_RST   = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;
    localparam int H_RST   = (IMAGE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RST;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered;
        logic                    last;
    } t_result;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [WDIM_W-1:0] r_width;
    logic [HDIM_W-1:0] r_height;
    logic [ROWC_W-1:0] r_mask [MASK_SIZE];

    logic [DIM_CFG_W:0] w_cfg_dim;
    logic [WDIM_W-1:0]  w_cfg_width;
    logic [HDIM_W-1:0]  w_cfg_height;
    logic               w_geom_wr;

    assign w_cfg_dim = {1'b0, i_cfg_wdata[DIM_CFG_W-1:0]};
    assign w_geom_wr = i_cfg_we && ((i_cfg_idx == REG_IMAGE_WIDTH)
                                    || (i_cfg_idx == REG_IMAGE_HEIGHT));

    // zero counts as one, anything above the maximum as the maximum
    always_comb begin
        if (w_cfg_dim == '0) begin
            w_cfg_width  = WDIM_W'(1);
            w_cfg_height = HDIM_W'(1);
        end else begin
            w_cfg_width  = (w_cfg_dim > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH) : WDIM_W'(w_cfg_dim);
            w_cfg_height = (w_cfg_dim > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(w_cfg_dim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WDIM_W'(W_RST);
            r_height <= HDIM_W'(H_RST);
            for (int i = 0; i < MASK_SIZE; i++) begin
                r_mask[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_width <= w_cfg_width;
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= w_cfg_height;
                end
                default: begin
                    // mask rows beyond the mask size are dropped
                    for (int i = 0; i < MASK_SIZE; i++) begin
                        if (i_cfg_idx == CFG_IDX_W'(REG_MASK_ROW0 + i)) begin
                            r_mask[i] <= i_cfg_wdata[ROWC_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stream position and output coordinates
    // ---------------------------------------------------------------
    logic [HDIM_W-1:0] r_in_row;
    logic [COL_W-1:0]  r_in_col;
    logic [XW-1:0]     r_out_x;
    logic [COL_W-1:0]  r_out_y;
    logic [LAG_W-1:0]  r_fill;

    logic [HDIM_W-1:0] n_in_row;
    logic [COL_W-1:0]  n_in_col;
    logic [XW-1:0]     n_out_x;
    logic [COL_W-1:0]  n_out_y;

    logic [LAG_W-1:0]  w_lag;
    logic              w_emit;
    logic              w_last;
    logic              w_col_end;
    logic              w_out_col_end;
    logic              w_out_row_end;
    logic              w_accept;
    logic              w_ready;
    logic [PIX_W-1:0]  w_sample;

    assign w_accept = i_pix.valid && w_ready;
    assign i_pix.ready = w_ready;

    // results start once half a mask of rows and columns has streamed in
    assign w_lag  = LAG_W'(HALF) * LAG_W'(r_width) + LAG_W'(HALF);
    assign w_emit = (r_fill == w_lag);

    assign w_col_end     = (WDIM_W'(r_in_col) + WDIM_W'(1)) == r_width;
    assign w_out_col_end = (WDIM_W'(r_out_y) + WDIM_W'(1)) == r_width;
    assign w_out_row_end = (HDIM_W'(r_out_x) + HDIM_W'(1)) == r_height;
    assign w_last        = w_out_col_end && w_out_row_end;

    // drains and anything past the frame's pixels enter as zero samples
    assign w_sample = (!i_pix.drain && (r_in_row < r_height)) ? i_pix.pixel : '0;

    always_comb begin
        n_in_col = w_col_end ? '0 : r_in_col + COL_W'(1);
        n_in_row = w_col_end ? r_in_row + HDIM_W'(1) : r_in_row;
        n_out_y  = w_out_col_end ? '0 : r_out_y + COL_W'(1);
        n_out_x  = w_out_col_end ? r_out_x + XW'(1) : r_out_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_geom_wr) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_out_x  <= '0;
            r_out_y  <= '0;
            r_fill   <= '0;
        end else if (w_accept) begin
            if (w_emit && w_last) begin
                // frame done, next transaction is pixel zero of a new frame
                r_in_row <= '0;
                r_in_col <= '0;
                r_out_x  <= '0;
                r_out_y  <= '0;
                r_fill   <= '0;
            end else begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
                if (w_emit) begin
                    r_out_x <= n_out_x;
                    r_out_y <= n_out_y;
                end else begin
                    r_fill <= r_fill + LAG_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: line memory read-modify-write
    // ---------------------------------------------------------------
    logic [LINE_W-1:0] mem_line [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_data;
    logic [LINE_W-1:0] r_fwd_word;
    logic              r_fwd;

    logic              r_s1_vld;
    logic              r_s1_emit;
    logic              r_s1_last;
    logic [PIX_W-1:0]  r_s1_sample;
    logic [COL_W-1:0]  r_s1_col;
    logic [XW-1:0]     r_s1_x;
    logic [COL_W-1:0]  r_s1_y;

    logic [LINE_W-1:0] w_lines;
    logic [LINE_W-1:0] w_new_word;
    logic [PIX_W-1:0]  w_colvec [MASK_SIZE];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= mem_line[r_in_col];
        end
        if (r_s1_vld) begin
            mem_line[r_s1_col] <= w_new_word;
        end
    end

    // word being written this cycle is what the next read at that column must see
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= w_accept && r_s1_vld && (r_s1_col == r_in_col);
        end
        r_fwd_word <= w_new_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
        if (w_accept) begin
            r_s1_emit   <= w_emit;
            r_s1_last   <= w_last;
            r_s1_sample <= w_sample;
            r_s1_col    <= r_in_col;
            r_s1_x      <= r_out_x;
            r_s1_y      <= r_out_y;
        end
    end

    // line a of the word holds the sample a+1 rows above
    assign w_lines    = r_fwd ? r_fwd_word : r_rd_data;
    assign w_new_word = {w_lines[LINE_W-PIX_W-1:0], r_s1_sample};

    always_comb begin
        for (int i = 0; i < MASK_SIZE - 1; i++) begin
            w_colvec[i] = w_lines[(MASK_SIZE - 2 - i) * PIX_W +: PIX_W];
        end
        w_colvec[MASK_SIZE-1] = r_s1_sample;
    end

    // ---------------------------------------------------------------
    // stage 2: window shift and masked products
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]  r_win [MASK_SIZE][MASK_SIZE];
    logic              r_s2_vld;
    logic              r_s2_emit;
    logic              r_s2_last;
    logic [XW-1:0]     r_s2_x;
    logic [COL_W-1:0]  r_s2_y;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            for (int i = 0; i < MASK_SIZE; i++) begin
                for (int j = 0; j < MASK_SIZE - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][MASK_SIZE-1] <= w_colvec[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_emit <= r_s1_emit;
        r_s2_last <= r_s1_last;
        r_s2_x    <= r_s1_x;
        r_s2_y    <= r_s1_y;
    end

    logic             w_row_ok [MASK_SIZE];
    logic             w_col_ok [MASK_SIZE];
    logic [PIX_W-1:0] w_tap    [MASK_SIZE][MASK_SIZE];

    // zero padding from the output coordinates
    always_comb begin
        for (int i = 0; i < MASK_SIZE; i++) begin
            if (i < HALF) begin
                w_row_ok[i] = HDIM_W'(r_s2_x) >= HDIM_W'(HALF - i);
                w_col_ok[i] = WDIM_W'(r_s2_y) >= WDIM_W'(HALF - i);
            end else begin
                w_row_ok[i] = (HDIM_W'(r_s2_x) + HDIM_W'(i - HALF)) < r_height;
                w_col_ok[i] = (WDIM_W'(r_s2_y) + WDIM_W'(i - HALF)) < r_width;
            end
        end
        for (int i = 0; i < MASK_SIZE; i++) begin
            for (int j = 0; j < MASK_SIZE; j++) begin
                w_tap[i][j] = (w_row_ok[i] && w_col_ok[j]) ? r_win[i][j] : '0;
            end
        end
    end

    logic signed [PROD_W-1:0] r_prod [MASK_SIZE][MASK_SIZE];
    logic                     r_s3_vld;
    logic                     r_s3_last;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MASK_SIZE; i++) begin
            for (int j = 0; j < MASK_SIZE; j++) begin
                r_prod[i][j] <= $signed(r_mask[i][j*COEF_W +: COEF_W])
                                * $signed({1'b0, w_tap[i][j]});
            end
        end
        r_s3_last <= r_s2_last;
    end

    // ---------------------------------------------------------------
    // stage 3 and 4: row sums, then the total
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] w_rowsum [MASK_SIZE];
    logic signed [SUM_W-1:0] r_rowsum [MASK_SIZE];
    logic signed [SUM_W-1:0] w_total;
    logic                    r_s4_vld;
    logic                    r_s4_last;

    always_comb begin
        for (int i = 0; i < MASK_SIZE; i++) begin
            w_rowsum[i] = '0;
            for (int j = 0; j < MASK_SIZE; j++) begin
                w_rowsum[i] = w_rowsum[i] + SUM_W'(r_prod[i][j]);
            end
        end
        w_total = '0;
        for (int i = 0; i < MASK_SIZE; i++) begin
            w_total = w_total + r_rowsum[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            // only positions that owe a result go on past the products
            r_s3_vld <= r_s2_vld && r_s2_emit;
            r_s4_vld <= r_s3_vld;
        end
        for (int i = 0; i < MASK_SIZE; i++) begin
            r_rowsum[i] <= w_rowsum[i];
        end
        r_s4_last <= r_s3_last;
    end

    // ---------------------------------------------------------------
    // output queue and input credit
    // ---------------------------------------------------------------
    t_result                 r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_fifo_cnt;
    logic [FIFO_CNT_W-1:0]   w_inflight;
    logic                    w_pop;

    assign w_pop      = o_res.valid && o_res.ready;
    assign w_inflight = FIFO_CNT_W'($countones({r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld}));
    // room for everything already in flight plus this transaction
    assign w_ready    = (w_inflight + r_fifo_cnt) < FIFO_CNT_W'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_s4_vld) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({r_s4_vld, w_pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + FIFO_CNT_W'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - FIFO_CNT_W'(1);
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
        if (r_s4_vld) begin
            r_fifo[r_wr_ptr] <= '{filtered: w_total, last: r_s4_last};
        end
    end

    assign o_res.valid    = (r_fifo_cnt != '0);
    assign o_res.filtered = r_fifo[r_rd_ptr].filtered;
    assign o_res.last     = r_fifo[r_rd_ptr].last;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ICV_ASSERT_IMPL(a_fifo_room, i_clk, i_rst_n, r_s4_vld, (r_fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || w_pop)
    `ICV_ASSERT_IMPL(a_credit, i_clk, i_rst_n, 1'b1, (w_inflight + r_fifo_cnt) <= FIFO_CNT_W'(FIFO_DEPTH))
    `ICV_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_accept && w_emit && w_last && !w_geom_wr, (r_fill == '0) && (r_out_x == '0) && (r_out_y == '0) && (r_in_col == '0))

endmodule

`default_nettype wire

/* tb/image_2d_convolution_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of image_2d_convolution: a directed table, then random frames
// checked transaction by transaction against a predictor kept in this file
// depends on icv_pkg, icv_pix_if, icv_res_if and the image_2d_convolution rtl

module image_2d_convolution_tb;
    import icv_pkg::*;

    // block geometry, kept equal to the instance parameters below
    localparam int MASK_SIZE  = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int HALF       = (MASK_SIZE - 1) / 2;
    // circular sample store, indexed by stream position modulo its size
    localparam int SAMPLE_DEPTH = (MASK_SIZE - 1) * MAX_WIDTH + MASK_SIZE;

    // register codes not named in the package
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW1 = REG_MASK_ROW0 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW2 = REG_MASK_ROW0 + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW3 = REG_MASK_ROW0 + 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW4 = REG_MASK_ROW0 + 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd7;

    localparam logic [CFG_DATA_W-1:0] ALL_ONES = {CFG_DATA_W{1'b1}};

    // run shaping
    localparam int    N_DIRECTED     = 41;
    localparam int    RANDOM_ITEMS   = 1450;
    localparam int    CALM_ITEMS     = 200;
    localparam int    PRESSURE_PHASE = 2;
    localparam int    LONG_HOLD      = 300;
    localparam int    SETTLE_CYCLES  = 16;
    localparam int    TAIL_CYCLES    = 32;
    localparam int    END_WAIT_LIMIT = 100000;
    localparam longint LIMIT_NS      = 64'd10_000_000;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered;
        logic                    last;
    } conv_result_t;

    typedef enum logic [1:0] {ACT_WRITE, ACT_PIXEL} step_kind_e;
    // where the expectation of a table row comes from
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_src_e;

    typedef struct packed {
        step_kind_e              kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [PIX_W-1:0]        pixel;
        logic                    drain;
        check_src_e              check;
        logic signed [SUM_W-1:0] want_filtered;
        logic                    want_last;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    icv_pix_if pix_bus ();
    icv_res_if res_bus ();

    image_2d_convolution #(
        .MASK_SIZE  (MASK_SIZE),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_bus),
        .o_res       (res_bus)
    );

    // ---------------------------------------------------------------------------------
    // predictor state: its own copy of the registers, the sample store and the counters
    // ---------------------------------------------------------------------------------
    logic [DIM_CFG_W-1:0]  cfg_width;
    logic [DIM_CFG_W-1:0]  cfg_height;
    logic [CFG_DATA_W-1:0] cfg_mask [5];
    logic [PIX_W-1:0]      sample_mem [SAMPLE_DEPTH];
    int unsigned           pos_row;
    int unsigned           pos_col;
    int unsigned           emitted;

    conv_result_t pending_results [$];
    stim_row_t    directed_rows [N_DIRECTED];

    int fail_count    = 0;
    int sent_items    = 0;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    bit long_hold_req = 1'b0;

    // clock: 4 ns period
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(input logic [DIM_CFG_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned frame_area();
        return clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
    endfunction

    // number of flush transactions that push the tail of a frame out
    function automatic int unsigned flush_len();
        return HALF * clamp_dim(cfg_width, MAX_WIDTH) + HALF;
    endfunction

    function automatic void restart_frame();
        pos_row = 0;
        pos_col = 0;
        emitted = 0;
    endfunction

    function automatic void reset_model();
        foreach (sample_mem[n]) sample_mem[n] = '0;
        foreach (cfg_mask[n]) cfg_mask[n] = '0;
        cfg_width  = DIM_CFG_W'(IMAGE_WIDTH_RST);
        cfg_height = DIM_CFG_W'(IMAGE_HEIGHT_RST);
        restart_frame();
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = data[DIM_CFG_W-1:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = data[DIM_CFG_W-1:0];
                restart_frame();
            end
            REG_MASK_ROW0, REG_MASK_ROW1, REG_MASK_ROW2, REG_MASK_ROW3, REG_MASK_ROW4: begin
                cfg_mask[idx - REG_MASK_ROW0] = data;
            end
            default: begin
                // unknown index: no effect
            end
        endcase
    endfunction

    // advances the predictor by one accepted pixel transaction; returns 1 when the
    // transaction releases a filtered result
    function automatic bit predict_conv(input logic [PIX_W-1:0] pix, input logic drn,
                                        output conv_result_t res);
        int unsigned w, h, total, lag, p, k, row, col;
        int          rr, cc, sum;
        logic signed [COEF_W-1:0] c;
        logic [PIX_W-1:0] s;
        w     = clamp_dim(cfg_width, MAX_WIDTH);
        h     = clamp_dim(cfg_height, MAX_HEIGHT);
        total = w * h;
        lag   = HALF * w + HALF;
        p     = pos_row * w + pos_col;
        res   = '0;

        // drains, and pixels past the end of the frame, go in as zero samples
        sample_mem[p % SAMPLE_DEPTH] = (!drn && p < total) ? pix : '0;

        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end

        if (p < lag) return 1'b0;
        k = emitted;
        if (k >= total) begin
            restart_frame();
            return 1'b0;
        end
        row = k / w;
        col = k % w;
        sum = 0;
        for (int i = 0; i < MASK_SIZE; i++) begin
            for (int j = 0; j < MASK_SIZE; j++) begin
                rr = int'(row) + i - HALF;
                cc = int'(col) + j - HALF;
                s  = '0;
                // zero padding outside the frame
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                    s = sample_mem[(rr * w + cc) % SAMPLE_DEPTH];
                c   = cfg_mask[i][COEF_W*j +: COEF_W];
                sum += int'(c) * int'(s);
            end
        end
        res.filtered = sum[SUM_W-1:0];
        res.last     = (k == total - 1);
        emitted++;
        if (res.last) restart_frame();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------------------
    // stimulus helpers; every task is entered and left at a falling edge
    // ---------------------------------------------------------------------------------
    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row      = '0;
        row.kind = ACT_WRITE;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic stim_row_t pix_row(input logic [PIX_W-1:0] pix, input logic drn,
                                          input check_src_e chk,
                                          input logic signed [SUM_W-1:0] f, input logic l);
        stim_row_t row;
        row               = '0;
        row.kind          = ACT_PIXEL;
        row.pixel         = pix;
        row.drain         = drn;
        row.check         = chk;
        row.want_filtered = f;
        row.want_last     = l;
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_mask_row();
        logic [CFG_DATA_W-1:0] row;
        row = CFG_DATA_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: begin
                // fully random, unused taps included
            end
            1: for (int t = 0; t < 5; t++) row[COEF_W*t +: COEF_W] = 12'h7ff;
            2: for (int t = 0; t < 5; t++) row[COEF_W*t +: COEF_W] = 12'h800;
            default: begin
                // a mix of zero, plus and minus 256, and the odd random tap
                for (int t = 0; t < 5; t++) begin
                    case ($urandom_range(0, 3))
                        0: row[COEF_W*t +: COEF_W] = 12'h000;
                        1: row[COEF_W*t +: COEF_W] = 12'h100;
                        2: row[COEF_W*t +: COEF_W] = 12'hf00;
                        default: ;
                    endcase
                end
            end
        endcase
        return row;
    endfunction

    // wait until every expected result is out, then let the pipeline empty of
    // transactions that release no result
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_config(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_geometry(input logic [DIM_CFG_W-1:0] w, input logic [DIM_CFG_W-1:0] h);
        if ($urandom_range(0, 1)) begin
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        end else begin
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        end
    endtask

    // offer one pixel transaction, after an optional idle burst, and predict on acceptance
    task automatic push_item(input logic [PIX_W-1:0] pix, input logic drn,
                             input check_src_e src, input conv_result_t typed);
        int           gap;
        bit           produced;
        conv_result_t res;
        gap = 0;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
            gap = $urandom_range(1, 15);
        if (gap != 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= pix;
        pix_bus.drain <= drn;
        do @(posedge i_clk); while (!pix_bus.ready);
        sent_items++;
        produced = predict_conv(pix, drn, res);
        case (src)
            CHK_MODEL: if (produced) pending_results.push_back(res);
            CHK_TYPED: pending_results.push_back(typed);
            default:   ;
        endcase
        @(negedge i_clk);
    endtask

    // send stream positions first .. first+count-1 of the current frame: pixels with the
    // odd drain inside the frame, then mostly drains with the odd pixel in the flush
    task automatic send_frame_part(input int unsigned first, input int unsigned count);
        int unsigned total;
        logic        drn;
        total = frame_area();
        for (int unsigned pos = first; pos < first + count; pos++) begin
            if (pos < total) drn = ($urandom_range(0, 15) == 0);
            else             drn = ($urandom_range(0, 3) != 0);
            push_item(rand_pixel(), drn, CHK_MODEL, '0);
        end
    endtask

    task automatic pick_idling(input bit calm);
        if (calm) begin
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
        end else begin
            case ($urandom_range(0, 2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 5;
                default: tx_gap_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 5;
                default: rx_stall_pct = 25;
            endcase
        end
    endtask

    // ---------------------------------------------------------------------------------
    // result side: ready with random stall bursts and one long hold-off on request
    // ---------------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left     = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (long_hold_req) begin
                // long hold-off: the output queue fills and the input has to stall
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                res_bus.ready <= 1'b0;
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                hold_left     = $urandom_range(1, 15) - 1;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin
        conv_result_t want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual filtered %0d last %0b",
                         $time, res_bus.filtered, res_bus.last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_bus.filtered !== want.filtered) begin
                    $display("%0t: filtered: expected %0d, actual %0d",
                             $time, want.filtered, res_bus.filtered);
                    fail_count++;
                end
                if (res_bus.last !== want.last) begin
                    $display("%0t: last: expected %0b, actual %0b",
                             $time, want.last, res_bus.last);
                    fail_count++;
                end
            end
        end
    end

    // hard limit on the whole run
    initial begin
        #(LIMIT_NS);
        $display("image_2d_convolution: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------
    initial begin
        int          rand_base, phase_no, n_frames, wait_cycles, pick;
        int unsigned len, cut;
        bit          need_restart;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        pix_bus.drain = 1'b0;
        reset_model();

        // directed table; a 1x1 frame needs two flush transactions and its one result is
        // the centre coefficient times the pixel, so those rows carry their result typed in
        directed_rows = '{
            // straight after reset: default 640 wide, far short of the first result
            pix_row(8'hff, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_NONE, 25'sd0, 1'b0),
            // 1x1 frame, largest positive centre tap, unused rows all ones
            reg_row(REG_IMAGE_WIDTH, 60'd1),
            reg_row(REG_IMAGE_HEIGHT, 60'd1),
            reg_row(REG_MASK_ROW0, 60'h0),
            reg_row(REG_MASK_ROW1, 60'h7ff000),
            reg_row(REG_MASK_ROW2, 60'h0),
            reg_row(REG_MASK_ROW3, ALL_ONES),
            reg_row(REG_MASK_ROW4, ALL_ONES),
            pix_row(8'hff, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_TYPED, 25'sd521985, 1'b1),
            // most negative centre tap, and a pixel in the flush that must be ignored
            reg_row(REG_MASK_ROW1, 60'h800000),
            pix_row(8'hff, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h5a, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_TYPED, -25'sd522240, 1'b1),
            // drain in place of the frame's pixel, then a full-scale pixel in the flush
            pix_row(8'h00, 1'b1, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'hff, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_TYPED, 25'sd0, 1'b1),
            // zero geometry counts as one
            reg_row(REG_IMAGE_WIDTH, 60'd0),
            reg_row(REG_IMAGE_HEIGHT, 60'd0),
            pix_row(8'h80, 1'b0, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_NONE, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_TYPED, -25'sd262144, 1'b1),
            // unknown index is dropped; then a 3x2 frame against the predictor
            reg_row(REG_SPARE, ALL_ONES),
            reg_row(REG_IMAGE_WIDTH, 60'd3),
            reg_row(REG_IMAGE_HEIGHT, 60'd2),
            reg_row(REG_MASK_ROW0, 60'hffffff7ff7ff7ff),
            reg_row(REG_MASK_ROW1, 60'hffffff7ff7ff7ff),
            reg_row(REG_MASK_ROW2, 60'h123456800801fff),
            pix_row(8'hff, 1'b0, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b0, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'hff, 1'b0, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b0, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'hff, 1'b0, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h01, 1'b0, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_MODEL, 25'sd0, 1'b0),
            pix_row(8'h00, 1'b1, CHK_MODEL, 25'sd0, 1'b0)
        };

        // reset held from time zero, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ACT_WRITE) begin
                settle();
                write_reg(directed_rows[n].idx, directed_rows[n].data);
            end else begin
                push_item(directed_rows[n].pixel, directed_rows[n].drain,
                          directed_rows[n].check,
                          {directed_rows[n].want_filtered, directed_rows[n].want_last});
            end
        end

        // widest frame (width above the maximum, clamped) and tallest frame, one row or
        // column each to keep the run short
        settle();
        pick_idling(1'b0);
        write_geometry(11'd2047, 11'd1);
        for (int r = 0; r < 5; r++) write_reg(REG_MASK_ROW0 + 3'(r), rand_mask_row());
        send_frame_part(0, frame_area() + flush_len());
        settle();
        write_geometry(11'd1, 11'd2047);
        send_frame_part(0, frame_area() + flush_len());

        // random phases: new settings while idle, then back-to-back frames, now and then
        // a frame cut short (restarted by a geometry write) or a mask change mid-frame
        need_restart = 1'b0;
        phase_no     = 0;
        rand_base    = sent_items;
        while (sent_items - rand_base < RANDOM_ITEMS) begin
            settle();
            pick_idling((sent_items - rand_base) >= RANDOM_ITEMS - CALM_ITEMS);
            if (phase_no == PRESSURE_PHASE) begin
                write_geometry(11'd16, 11'd8);
                long_hold_req = 1'b1;
            end else if (need_restart || $urandom_range(0, 2) == 0) begin
                write_geometry(DIM_CFG_W'($urandom_range(0, 12)),
                               DIM_CFG_W'($urandom_range(0, 8)));
            end
            need_restart = 1'b0;
            for (int r = 0; r < 5; r++)
                if ($urandom_range(0, 1)) write_reg(REG_MASK_ROW0 + 3'(r), rand_mask_row());
            if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, CFG_DATA_W'({$urandom, $urandom}));

            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                len  = frame_area() + flush_len();
                cut  = $urandom_range(1, len - 1);
                pick = $urandom_range(0, 9);
                if (pick == 0 && phase_no != PRESSURE_PHASE) begin
                    // broken frame: left unfinished, the next phase restarts it
                    send_frame_part(0, cut);
                    need_restart = 1'b1;
                    break;
                end else if (pick == 1) begin
                    // mask change mid-frame, applies from the next result on
                    send_frame_part(0, cut);
                    settle();
                    write_reg(REG_MASK_ROW0 + 3'($urandom_range(0, 4)), rand_mask_row());
                    send_frame_part(cut, len - cut);
                end else begin
                    send_frame_part(0, len);
                end
            end
            phase_no++;
        end

        // wind down: everything expected must arrive, then a quiet tail
        pix_bus.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < END_WAIT_LIMIT) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: missing results: expected %0d more, actual none",
                     $time, pending_results.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("image_2d_convolution: match");
        end else begin
            $display("image_2d_convolution: mismatch");
        end
        $finish;
    end

endmodule
